// File: hdl/lsg_pkg.sv
// lsg_pkg: shared constants, types and helper functions for the line substring grep unit
// no dependencies; compiled first
package lsg_pkg;

  // sizes
  localparam int PATTERN_MAX_DEF = 32;
  localparam int PAT_BYTES       = 32;
  localparam int CNT_W           = 32;
  localparam int PAT_LEN_W       = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int FIFO_DEPTH      = 4;

  // character codes
  localparam logic [7:0] NEWLINE     = 8'd10;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IGN_CASE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY = 3'd7;

  // result kinds
  localparam logic KIND_LINE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef struct packed {
    logic [8*PAT_BYTES-1:0] pat;
    logic [PAT_LEN_W-1:0]   pat_len;
    logic                   ign_case;
    logic                   invert;
    logic                   count_only;
  } cfg_t;

  typedef struct packed {
    logic             result_kind;
    logic [CNT_W-1:0] line_number;
    logic [CNT_W-1:0] line_offset;
    logic [CNT_W-1:0] line_length;
    logic [CNT_W-1:0] match_count;
    logic             last_result;
  } result_t;

  // up to two results produced by one byte, r0 leaves first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == CNT_SAT) ? v : v + CNT_W'(1);
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic on);
    logic [7:0] r;
    r = (on && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
    return r;
  endfunction

endpackage

// File: hdl/lsg_intf.sv
// lsg_intf: valid/ready channel interfaces for text bytes, results and configuration writes
// depends on lsg_pkg
interface lsg_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface lsg_result_if;
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [lsg_pkg::CNT_W-1:0] line_number;
  logic [lsg_pkg::CNT_W-1:0] line_offset;
  logic [lsg_pkg::CNT_W-1:0] line_length;
  logic [lsg_pkg::CNT_W-1:0] match_count;
  logic                      last_result;
  modport source (output valid, result_kind, line_number, line_offset, line_length,
                  match_count, last_result, input ready);
  modport sink (input valid, result_kind, line_number, line_offset, line_length,
                match_count, last_result, output ready);
endinterface

interface lsg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lsg_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [lsg_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

// File: hdl/lsg_cfg_regs.sv
// lsg_cfg_regs: configuration register file written over the config channel
// depends on lsg_pkg
module lsg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [lsg_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lsg_pkg::CFG_DATA_W-1:0] wr_data,
  output lsg_pkg::cfg_t                  cfg
);

  // register writes, one per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        lsg_pkg::REG_PAT0:       cfg.pat[63:0]    <= wr_data;
        lsg_pkg::REG_PAT1:       cfg.pat[127:64]  <= wr_data;
        lsg_pkg::REG_PAT2:       cfg.pat[191:128] <= wr_data;
        lsg_pkg::REG_PAT3:       cfg.pat[255:192] <= wr_data;
        lsg_pkg::REG_PAT_LEN:    cfg.pat_len      <= wr_data[lsg_pkg::PAT_LEN_W-1:0];
        lsg_pkg::REG_IGN_CASE:   cfg.ign_case     <= wr_data[0];
        lsg_pkg::REG_INVERT:     cfg.invert       <= wr_data[0];
        lsg_pkg::REG_COUNT_ONLY: cfg.count_only   <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/lsg_matcher.sv
// lsg_matcher: shift-and match vector, line bookkeeping and result generation per byte
// depends on lsg_pkg
module lsg_matcher #(
  parameter int PATTERN_MAX = lsg_pkg::PATTERN_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lsg_pkg::cfg_t cfg,
  input  logic          proc,
  input  logic [7:0]    in_byte,
  input  logic          in_eot,
  output lsg_pkg::push_t push
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int CW = lsg_pkg::CNT_W;

  logic [PATTERN_MAX-1:0] pm, pm_next, pm_upd, eq, last_mask;
  logic                   found, found_next;
  logic [CW-1:0]          len, len_next, num, num_next, off, off_next;
  logic [CW-1:0]          pos, pos_next, cnt, cnt_next;
  logic [LW-1:0]          m;
  logic [7:0]             fc, pb;
  logic                   is_nl, sel, rep_vld;
  lsg_pkg::result_t       rep, fin;

  // effective pattern length, clamped to the vector size
  always_comb begin
    if ({1'b0, cfg.pat_len} > 7'(PATTERN_MAX)) begin
      m = LW'(PATTERN_MAX);
    end else begin
      m = LW'(cfg.pat_len);
    end
  end

  // per-position compare of the byte against each pattern byte
  always_comb begin
    fc = lsg_pkg::fold(in_byte, cfg.ign_case);
    pb = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < lsg_pkg::PAT_BYTES) begin
        pb = cfg.pat[8*(i % lsg_pkg::PAT_BYTES) +: 8];
      end else begin
        pb = '0;
      end
      eq[i]        = (i < int'(m)) && (lsg_pkg::fold(pb, cfg.ign_case) == fc);
      last_mask[i] = (int'(m) == i + 1);
    end
    pm_upd = ((pm << 1) | PATTERN_MAX'(1)) & eq;
  end

  // next state and results
  always_comb begin
    is_nl      = (in_byte == lsg_pkg::NEWLINE);
    pos_next   = lsg_pkg::sat_inc(pos);
    pm_next    = pm;
    found_next = found;
    len_next   = len;
    num_next   = num;
    cnt_next   = cnt;
    off_next   = off;
    rep_vld    = 1'b0;
    rep        = '0;
    fin        = '0;

    if (!is_nl) begin
      if (m != '0) begin
        pm_next = pm_upd;
        if (|(pm_upd & last_mask)) begin
          found_next = 1'b1;
        end
      end
      len_next = lsg_pkg::sat_inc(len);
    end

    sel = (m == '0) || found_next;
    if (cfg.invert) begin
      sel = !sel;
    end

    // line end: report and restart line state
    if (is_nl || in_eot) begin
      num_next = lsg_pkg::sat_inc(num);
      if (sel) begin
        cnt_next = lsg_pkg::sat_inc(cnt);
      end
      rep_vld         = sel && !cfg.count_only;
      rep.result_kind = lsg_pkg::KIND_LINE;
      rep.line_number = num_next;
      rep.line_offset = off;
      rep.line_length = len_next;
      rep.match_count = cnt_next;
      rep.last_result = 1'b0;
      pm_next    = '0;
      found_next = 1'b0;
      len_next   = '0;
      off_next   = pos_next;
    end

    fin.result_kind = lsg_pkg::KIND_COUNT;
    fin.match_count = cnt_next;
    fin.last_result = 1'b1;

    // text end clears everything
    if (in_eot) begin
      pm_next    = '0;
      found_next = 1'b0;
      len_next   = '0;
      num_next   = '0;
      off_next   = '0;
      pos_next   = '0;
      cnt_next   = '0;
    end
  end

  // push bundle toward the result queue
  always_comb begin
    push = '0;
    if (rep_vld) begin
      push.r0 = rep;
      push.r1 = fin;
      push.n  = in_eot ? 2'd2 : 2'd1;
    end else begin
      push.r0 = fin;
      push.r1 = fin;
      push.n  = in_eot ? 2'd1 : 2'd0;
    end
    if (!proc) begin
      push.n = 2'd0;
    end
  end

  // per-text state
  always_ff @(posedge clk) begin
    if (rst) begin
      pm    <= '0;
      found <= 1'b0;
      len   <= '0;
      num   <= '0;
      off   <= '0;
      pos   <= '0;
      cnt   <= '0;
    end else if (proc) begin
      pm    <= pm_next;
      found <= found_next;
      len   <= len_next;
      num   <= num_next;
      off   <= off_next;
      pos   <= pos_next;
      cnt   <= cnt_next;
    end
  end

  // end of text leaves a clean slate
  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && in_eot) |=> (pos == '0 && cnt == '0 && num == '0 && pm == '0))
    else $error("per-text state not cleared after end of text");

  // a double push is always a line report followed by the final count
  a_two_order: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (push.r0.result_kind == lsg_pkg::KIND_LINE &&
                          push.r1.last_result))
    else $error("double push out of order");

endmodule

// File: hdl/lsg_result_fifo.sv
// lsg_result_fifo: small result queue, up to two writes and one read per cycle
// depends on lsg_pkg
module lsg_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  lsg_pkg::push_t   push,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_ready,
  output lsg_pkg::result_t out_data
);

  localparam int Depth = lsg_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);

  lsg_pkg::result_t mem [Depth];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= CW'(Depth - 2));

  // storage writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.r1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + CW'(push.n) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (count + CW'(push.n) <= CW'(Depth)))
    else $error("result queue overflow");

  a_level_track: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd0 && pop) |=> (count == $past(count) - CW'(1)))
    else $error("result queue level wrong after transfer");

endmodule

// File: hdl/line_substring_grep_unit.sv
// line_substring_grep_unit: top level of the fixed-string line filter
// depends on lsg_pkg, lsg_intf, lsg_cfg_regs, lsg_matcher, lsg_result_fifo
//
//   channel   dir  fields
//   byte_in   in   text_byte[7:0], end_of_text
//   res_out   out  result_kind, line_number, line_offset, line_length,
//                  match_count, last_result (32-bit counters)
//   cfg       in   reg_index[2:0], data[63:0]
//
// one byte per cycle while the queue has room: a byte is captured in the input register,
// then matched and pushed into a four-entry result queue. a byte ending the text yields
// up to two results, drained one per cycle while res_out is ready.
// input ready drops only when the queue holds more than two results.
// synchronous reset clears config and all text state; cfg is always ready.
module line_substring_grep_unit #(
  parameter int PATTERN_MAX = lsg_pkg::PATTERN_MAX_DEF
) (
  input logic          clk,
  input logic          rst,
  lsg_byte_if.sink     byte_in,
  lsg_result_if.source res_out,
  lsg_cfg_if.sink      cfg
);

  lsg_pkg::cfg_t    cfg_q;
  lsg_pkg::push_t   push;
  lsg_pkg::result_t out_data;
  logic             in_vld, in_eot, room2, proc;
  logic [7:0]       in_byte;

  // configuration
  assign cfg.ready = 1'b1;

  lsg_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.reg_index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  // input register
  assign proc          = in_vld && room2;
  assign byte_in.ready = !in_vld || room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (byte_in.ready) begin
      in_vld <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.text_byte;
      in_eot  <= byte_in.end_of_text;
    end
  end

  lsg_matcher #(.PATTERN_MAX(PATTERN_MAX)) u_match (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_q),
    .proc    (proc),
    .in_byte (in_byte),
    .in_eot  (in_eot),
    .push    (push)
  );

  lsg_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_data  (out_data)
  );

  // result payload
  assign res_out.result_kind = out_data.result_kind;
  assign res_out.line_number = out_data.line_number;
  assign res_out.line_offset = out_data.line_offset;
  assign res_out.line_length = out_data.line_length;
  assign res_out.match_count = out_data.match_count;
  assign res_out.last_result = out_data.last_result;

endmodule
